[hdl/opq_pkg.sv]
// Shared types, codes and the ordering comparator for the ordered priority queue.
// Used by opq_cell and ordered_priority_queue_top; depends on nothing else.
`timescale 1ns / 1ps

package opq_pkg;

  localparam int DATA_W = 32;

  // Ordering rules selected by the mode register.
  localparam logic [1:0] MODE_HIGH_FIRST = 2'd0;
  localparam logic [1:0] MODE_LOW_FIRST  = 2'd1;
  localparam logic [1:0] MODE_FIFO       = 2'd2;
  localparam logic [1:0] MODE_LIFO       = 2'd3;

  // Commands.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_INSERTED     = 2'd0;
  localparam logic [1:0] STATUS_EXTRACTED    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY_REFUSE = 2'd2;
  localparam logic [1:0] STATUS_FULL_REFUSE  = 2'd3;

  // One stored pair.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } slot_t;

  // An operation travelling down the cell row, one cell per cycle.
  typedef struct packed {
    logic                     active;
    logic                     extract;
    logic                     displace;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } wave_t;

  // True when a new priority may be placed in front of a stored one.
  function automatic logic passes(input logic [1:0] mode,
                                  input logic signed [DATA_W-1:0] new_prio,
                                  input logic signed [DATA_W-1:0] old_prio);
    logic result;
    case (mode)
      MODE_HIGH_FIRST: result = (new_prio > old_prio);
      MODE_LOW_FIRST:  result = (new_prio < old_prio);
      MODE_FIFO:       result = 1'b0;
      MODE_LIFO:       result = 1'b1;
      default:         result = 1'b0;
    endcase
    return result;
  endfunction

endpackage

[hdl/ordered_priority_queue_top.sv]
// Top level of the ordered priority queue: handshakes, fill count and the cell row.
// Depends on opq_pkg and opq_cell.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid / in_ready         command, item_value, item_priority
//   out      output     out_valid / out_ready       status, head_value, head_priority,
//                                                   now_empty
//   cfg      input      cfg_write_en                cfg_write_data (order mode)
//
// Transfers never fall on consecutive cycles: each operation enters cell 0 and moves
// one cell per cycle, so consecutive operations stay at least two cells apart in the row.
// The result is registered at the input transfer and is offered on the next cycle.
// A result waiting on out_ready blocks further input transfers until it is taken.
// Synchronous reset empties the row by clearing the valid bit of every cell.
// Each operation carries the order mode it was issued with.
`timescale 1ns / 1ps

module ordered_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic signed [opq_pkg::DATA_W-1:0]    item_value,
  input  logic signed [opq_pkg::DATA_W-1:0]    item_priority,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic signed [opq_pkg::DATA_W-1:0]    head_value,
  output logic signed [opq_pkg::DATA_W-1:0]    head_priority,
  output logic                                 now_empty,
  input  logic                                 cfg_write_en,
  input  logic [1:0]                           cfg_write_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

  logic [1:0]       order_mode;
  logic [CNT_W-1:0] count;
  logic             spacing;
  logic             in_fire;
  logic             is_full;
  logic             is_empty;

  opq_pkg::wave_t wave_head;
  opq_pkg::wave_t wave_link [CAPACITY];
  opq_pkg::slot_t slots     [CAPACITY];

  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);
  assign in_ready = !spacing && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode       <= opq_pkg::MODE_HIGH_FIRST;
      count            <= '0;
      spacing          <= 1'b0;
      out_valid        <= 1'b0;
      wave_head.active <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        order_mode <= cfg_write_data;
      end
      spacing          <= in_fire;
      wave_head.active <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        out_valid          <= 1'b1;
        head_value         <= '0;
        head_priority      <= '0;
        now_empty          <= 1'b0;
        wave_head.mode     <= order_mode;
        wave_head.displace <= 1'b0;
        wave_head.value    <= item_value;
        wave_head.prio     <= item_priority;
        if (command == opq_pkg::CMD_EXTRACT) begin
          wave_head.extract <= 1'b1;
          if (is_empty) begin
            status    <= opq_pkg::STATUS_EMPTY_REFUSE;
            now_empty <= 1'b1;
          end else begin
            // Cell 0 is current here: the previous operation has already left it.
            status           <= opq_pkg::STATUS_EXTRACTED;
            head_value       <= slots[0].value;
            head_priority    <= slots[0].prio;
            now_empty        <= (count == ONE_COUNT);
            count            <= count - ONE_COUNT;
            wave_head.active <= 1'b1;
          end
        end else begin
          wave_head.extract <= 1'b0;
          if (is_full) begin
            status <= opq_pkg::STATUS_FULL_REFUSE;
          end else begin
            status           <= opq_pkg::STATUS_INSERTED;
            count            <= count + ONE_COUNT;
            wave_head.active <= 1'b1;
          end
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    opq_pkg::wave_t cell_in;
    opq_pkg::slot_t cell_right;

    if (i == 0) begin : g_first
      assign cell_in = wave_head;
    end else begin : g_inner
      assign cell_in = wave_link[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign cell_right = '0;
    end else begin : g_mid
      assign cell_right = slots[i+1];
    end

    opq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (cell_in),
      .right    (cell_right),
      .slot     (slots[i]),
      .wave_out (wave_link[i])
    );
  end

  // A non-full insert always finds a free cell, so nothing falls off the end.
  assert property (@(posedge clk) disable iff (rst) !wave_link[CAPACITY-1].active)
    else $error("operation ran past the last cell");

  // Input transfers never fall on consecutive cycles.
  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_fire)
    else $error("input transfers on consecutive cycles");

  // Whenever a transfer may happen, cell 0 agrees with the fill count.
  assert property (@(posedge clk) disable iff (rst) !spacing |-> (slots[0].valid == !is_empty))
    else $error("head cell disagrees with fill count");

  // An extract result is empty exactly when the count reached zero.
  assert property (@(posedge clk) disable iff (rst)
      (in_fire && command == opq_pkg::CMD_EXTRACT) |=> (now_empty == is_empty))
    else $error("empty flag disagrees with fill count");

endmodule

[hdl/opq_cell.sv]
// One cell of the sorted row: holds a single pair and hands operations on.
// Depends on opq_pkg for the slot and wave types and the comparator.
`timescale 1ns / 1ps

module opq_cell (
  input  logic           clk,
  input  logic           rst,
  input  opq_pkg::wave_t wave_in,
  input  opq_pkg::slot_t right,
  output opq_pkg::slot_t slot,
  output opq_pkg::wave_t wave_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid      <= 1'b0;
      wave_out.active <= 1'b0;
    end else begin
      wave_out.active <= 1'b0;
      if (wave_in.active) begin
        if (wave_in.extract) begin
          // Pull the neighbor's pair forward; the hole moves on while pairs remain.
          slot            <= right;
          wave_out        <= wave_in;
          wave_out.active <= right.valid;
        end else if (!slot.valid) begin
          slot.valid <= 1'b1;
          slot.value <= wave_in.value;
          slot.prio  <= wave_in.prio;
        end else if (wave_in.displace ||
                     opq_pkg::passes(wave_in.mode, wave_in.prio, slot.prio)) begin
          // Once the new pair is placed, every later pair shifts back by one.
          slot.value        <= wave_in.value;
          slot.prio         <= wave_in.prio;
          wave_out          <= wave_in;
          wave_out.displace <= 1'b1;
          wave_out.value    <= slot.value;
          wave_out.prio     <= slot.prio;
        end else begin
          wave_out <= wave_in;
        end
      end
    end
  end

endmodule
